[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when built for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop on every rising clk edge, off while rst_n is low.
`define IRPDV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check prop on every rising clk edge, reset included.
`define IRPDV_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IRPDV_ASSERT(label, clk, rst_n, prop, msg)
`define IRPDV_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[hdl/irpdv_pkg.sv]
// ---------------------------------------------------------------------------
// irpdv_pkg
// Types, sizes and register codes of the IR pulse-distance volume decoder.
// ---------------------------------------------------------------------------
package irpdv_pkg;

  localparam int unsigned HOLD_TICKS = 19200;
  localparam int unsigned FRAME_BITS = 32;

  localparam int unsigned DUR_W     = 16;
  localparam int unsigned HOLD_W    = 15;
  localparam int unsigned BIT_IDX_W = 6;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [BIT_IDX_W-1:0] FRAME_BITS_L = BIT_IDX_W'(FRAME_BITS);
  localparam logic [HOLD_W-1:0]    HOLD_TICKS_L = HOLD_W'(HOLD_TICKS);
  localparam logic [DUR_W-1:0]     DUR_MAX      = {DUR_W{1'b1}};
  localparam logic [DUR_W-1:0]     DUR_ONE      = DUR_W'(1);

  // Register reset values
  localparam logic [BYTE_W-1:0] DEVICE_ID_RST  = 8'h10;
  localparam logic [BYTE_W-1:0] UP_CODE_RST    = 8'h20;
  localparam logic [BYTE_W-1:0] DOWN_CODE_RST  = 8'h30;
  localparam logic [DUR_W-1:0]  LEAD_BURST_RST = 16'd9500;
  localparam logic [DUR_W-1:0]  LEAD_SPACE_RST = 16'd5000;
  localparam logic [DUR_W-1:0]  BIT_BURST_RST  = 16'd700;
  localparam logic [DUR_W-1:0]  BIT_SPACE_RST  = 16'd1800;
  localparam logic [DUR_W-1:0]  ONE_THRESH_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ID    = 3'd0,
    REG_UP_CODE      = 3'd1,
    REG_DOWN_CODE    = 3'd2,
    REG_LEAD_BURST   = 3'd3,
    REG_LEAD_SPACE   = 3'd4,
    REG_BIT_BURST    = 3'd5,
    REG_BIT_SPACE    = 3'd6,
    REG_ONE_THRESH   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_LEAD_LOW  = 3'd1,
    PH_LEAD_HIGH = 3'd2,
    PH_BIT_LOW   = 3'd3,
    PH_BIT_HIGH  = 3'd4,
    PH_TAIL      = 3'd5
  } phase_t;

endpackage

[hdl/irpdv_if.sv]
// ---------------------------------------------------------------------------
// irpdv_if
// Valid/ready channels of the decoder: line samples in, decode results out.
// ---------------------------------------------------------------------------
interface irpdv_in_if;
  logic valid;
  logic ready;
  logic ir_level;

  modport source (output valid, output ir_level, input ready);
  modport sink   (input valid, input ir_level, output ready);
endinterface

interface irpdv_out_if;
  logic       valid;
  logic       ready;
  logic       vol_up;
  logic       vol_down;
  logic       frame_done;
  logic       frame_abort;
  logic [7:0] rx_address;
  logic [7:0] rx_address_inv;
  logic [7:0] rx_command;
  logic [7:0] rx_command_inv;

  modport source (output valid, output vol_up, output vol_down, output frame_done,
                  output frame_abort, output rx_address, output rx_address_inv,
                  output rx_command, output rx_command_inv, input ready);
  modport sink   (input valid, input vol_up, input vol_down, input frame_done,
                  input frame_abort, input rx_address, input rx_address_inv,
                  input rx_command, input rx_command_inv, output ready);
endinterface

[hdl/ir_pulse_distance_volume_decoder_unit.sv]
// ---------------------------------------------------------------------------
// ir_pulse_distance_volume_decoder_unit
// Pulse-distance IR frame decoder that latches volume up/down motor drives.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  carries one IR line sample (ir_level, 0 = burst, 1 = idle) per
//          tick. Every accepted sample produces exactly one item on out_ch.
//   out_ch carries the drive levels after that sample, frame_done and
//          frame_abort strobes and the four bytes of the last complete frame.
//   cfg_*  writes one of the eight registers (address, codes, time limits)
//          at any edge with cfg_we high; write only while the block is idle.
// Each result is registered and shown on out_ch in the cycle after acceptance.
// Throughput: one sample per cycle unless out_ch stalls. The decode is a single
//   pass of compare and increment logic between the state and output registers.
// Stall: in_ch.ready stays high while the output register is empty or being
//   drained; with the receiver stalled the finished item holds in the output
//   register and the next sample waits.
// Reset (rst_n low, synchronous): registers return to their defaults, the
//   decoder goes idle, drives and received bytes clear, out_ch empties and
//   in_ch.ready stays low.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ir_pulse_distance_volume_decoder_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  irpdv_in_if.sink                             in_ch,
  irpdv_out_if.source                          out_ch,
  input  logic                                 cfg_we,
  input  logic [irpdv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [irpdv_pkg::CFG_DAT_W-1:0]      cfg_data
);

  localparam int unsigned DW = irpdv_pkg::DUR_W;
  localparam int unsigned BW = irpdv_pkg::BYTE_W;

  // Configuration registers
  logic [BW-1:0] device_id_r, up_code_r, down_code_r;
  logic [DW-1:0] lead_burst_r, lead_space_r, bit_burst_r, bit_space_r, one_thresh_r;

  // Decoder state
  irpdv_pkg::phase_t                  phase_r, phase_nxt;
  logic [DW-1:0]                      dur_r, dur_nxt;
  logic [irpdv_pkg::BIT_IDX_W-1:0]    bidx_r, bidx_nxt;
  logic [irpdv_pkg::WORD_W-1:0]       shift_r, shift_nxt;
  logic [irpdv_pkg::WORD_W-1:0]       rxw_r, rxw_nxt;
  logic                               up_r, up_nxt;
  logic                               down_r, down_nxt;
  logic [irpdv_pkg::HOLD_W-1:0]       hold_r, hold_nxt;
  logic                               done_nxt, abort_nxt;

  // Output register
  logic                               out_valid_r;
  logic                               out_up_r, out_down_r, out_done_r, out_abort_r;
  logic [irpdv_pkg::WORD_W-1:0]       out_word_r;

  logic                               in_fire;
  logic                               high;
  logic [DW-1:0]                      dur_inc;
  logic [irpdv_pkg::BIT_IDX_W-1:0]    bidx_inc;
  logic [irpdv_pkg::WORD_W-1:0]       shift_bit;
  logic [irpdv_pkg::HOLD_W-1:0]       hold_inc;

  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign high        = in_ch.ir_level;
  assign dur_inc     = (dur_r == irpdv_pkg::DUR_MAX) ? dur_r : dur_r + irpdv_pkg::DUR_ONE;
  assign bidx_inc    = bidx_r + irpdv_pkg::BIT_IDX_W'(1);
  assign hold_inc    = hold_r + irpdv_pkg::HOLD_W'(1);

  always_comb begin
    shift_bit = shift_r;
    shift_bit[bidx_r[4:0]] = 1'b1;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r  <= irpdv_pkg::DEVICE_ID_RST;
      up_code_r    <= irpdv_pkg::UP_CODE_RST;
      down_code_r  <= irpdv_pkg::DOWN_CODE_RST;
      lead_burst_r <= irpdv_pkg::LEAD_BURST_RST;
      lead_space_r <= irpdv_pkg::LEAD_SPACE_RST;
      bit_burst_r  <= irpdv_pkg::BIT_BURST_RST;
      bit_space_r  <= irpdv_pkg::BIT_SPACE_RST;
      one_thresh_r <= irpdv_pkg::ONE_THRESH_RST;
    end else if (cfg_we) begin
      unique case (irpdv_pkg::cfg_reg_t'(cfg_index))
        irpdv_pkg::REG_DEVICE_ID:  device_id_r  <= cfg_data[BW-1:0];
        irpdv_pkg::REG_UP_CODE:    up_code_r    <= cfg_data[BW-1:0];
        irpdv_pkg::REG_DOWN_CODE:  down_code_r  <= cfg_data[BW-1:0];
        irpdv_pkg::REG_LEAD_BURST: lead_burst_r <= cfg_data;
        irpdv_pkg::REG_LEAD_SPACE: lead_space_r <= cfg_data;
        irpdv_pkg::REG_BIT_BURST:  bit_burst_r  <= cfg_data;
        irpdv_pkg::REG_BIT_SPACE:  bit_space_r  <= cfg_data;
        irpdv_pkg::REG_ONE_THRESH: one_thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state for one line sample
  always_comb begin
    phase_nxt = phase_r;
    dur_nxt   = dur_r;
    bidx_nxt  = bidx_r;
    shift_nxt = shift_r;
    rxw_nxt   = rxw_r;
    up_nxt    = up_r;
    down_nxt  = down_r;
    hold_nxt  = hold_r;
    done_nxt  = 1'b0;
    abort_nxt = 1'b0;

    unique case (phase_r)
      irpdv_pkg::PH_LEAD_LOW: begin
        if (!high) begin
          dur_nxt = dur_inc;
        end else if (dur_r > lead_burst_r) begin
          phase_nxt = irpdv_pkg::PH_IDLE;
          abort_nxt = 1'b1;
        end else begin
          phase_nxt = irpdv_pkg::PH_LEAD_HIGH;
          dur_nxt   = irpdv_pkg::DUR_ONE;
        end
      end
      irpdv_pkg::PH_LEAD_HIGH: begin
        if (high) begin
          dur_nxt = dur_inc;
          if (dur_inc > lead_space_r) begin
            phase_nxt = irpdv_pkg::PH_IDLE;
            abort_nxt = 1'b1;
          end
        end else begin
          phase_nxt = irpdv_pkg::PH_BIT_LOW;
          dur_nxt   = irpdv_pkg::DUR_ONE;
          bidx_nxt  = '0;
          shift_nxt = '0;
        end
      end
      irpdv_pkg::PH_BIT_LOW: begin
        if (!high) begin
          dur_nxt = dur_inc;
        end else if (dur_r > bit_burst_r) begin
          phase_nxt = irpdv_pkg::PH_IDLE;
          abort_nxt = 1'b1;
        end else begin
          phase_nxt = irpdv_pkg::PH_BIT_HIGH;
          dur_nxt   = irpdv_pkg::DUR_ONE;
        end
      end
      irpdv_pkg::PH_BIT_HIGH: begin
        if (high) begin
          dur_nxt = dur_inc;
          if (dur_inc > bit_space_r) begin
            phase_nxt = irpdv_pkg::PH_IDLE;
            abort_nxt = 1'b1;
          end
        end else begin
          // Falling edge closes the space: decide the bit
          if (dur_r > one_thresh_r) begin
            shift_nxt = shift_bit;
          end
          bidx_nxt = bidx_inc;
          if (bidx_inc >= irpdv_pkg::FRAME_BITS_L) begin
            rxw_nxt   = shift_nxt;
            done_nxt  = 1'b1;
            phase_nxt = irpdv_pkg::PH_TAIL;
            if (shift_nxt[7:0] == device_id_r) begin
              priority if (shift_nxt[23:16] == up_code_r) begin
                up_nxt = 1'b1;
              end else if (shift_nxt[23:16] == down_code_r) begin
                down_nxt = 1'b1;
              end else begin
                // Other commands leave both drives as they are
              end
            end
          end else begin
            phase_nxt = irpdv_pkg::PH_BIT_LOW;
            dur_nxt   = irpdv_pkg::DUR_ONE;
          end
        end
      end
      irpdv_pkg::PH_TAIL: begin
        if (high) begin
          phase_nxt = irpdv_pkg::PH_IDLE;
          hold_nxt  = irpdv_pkg::HOLD_W'(1);
          if (irpdv_pkg::HOLD_TICKS_L <= irpdv_pkg::HOLD_W'(1)) begin
            up_nxt   = 1'b0;
            down_nxt = 1'b0;
          end
        end
      end
      default: begin
        // Idle; unused phase codes fall back here
        phase_nxt = irpdv_pkg::PH_IDLE;
        if (high) begin
          if (hold_r < irpdv_pkg::HOLD_TICKS_L) begin
            hold_nxt = hold_inc;
            if (hold_inc >= irpdv_pkg::HOLD_TICKS_L) begin
              up_nxt   = 1'b0;
              down_nxt = 1'b0;
            end
          end
        end else begin
          hold_nxt  = '0;
          phase_nxt = irpdv_pkg::PH_LEAD_LOW;
          dur_nxt   = irpdv_pkg::DUR_ONE;
        end
      end
    endcase

    // Restart the hold-down count whenever idle is left
    if (phase_nxt != irpdv_pkg::PH_IDLE) begin
      hold_nxt = '0;
    end
  end

  // State registers advance on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= irpdv_pkg::PH_IDLE;
      dur_r   <= '0;
      bidx_r  <= '0;
      shift_r <= '0;
      rxw_r   <= '0;
      up_r    <= 1'b0;
      down_r  <= 1'b0;
      hold_r  <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      dur_r   <= dur_nxt;
      bidx_r  <= bidx_nxt;
      shift_r <= shift_nxt;
      rxw_r   <= rxw_nxt;
      up_r    <= up_nxt;
      down_r  <= down_nxt;
      hold_r  <= hold_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_up_r    <= up_nxt;
      out_down_r  <= down_nxt;
      out_done_r  <= done_nxt;
      out_abort_r <= abort_nxt;
      out_word_r  <= rxw_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.vol_up         = out_up_r;
  assign out_ch.vol_down       = out_down_r;
  assign out_ch.frame_done     = out_done_r;
  assign out_ch.frame_abort    = out_abort_r;
  assign out_ch.rx_address     = out_word_r[7:0];
  assign out_ch.rx_address_inv = out_word_r[15:8];
  assign out_ch.rx_command     = out_word_r[23:16];
  assign out_ch.rx_command_inv = out_word_r[31:24];

  `IRPDV_ASSERT(a_done_in_tail, clk, rst_n,
    (out_valid_r && out_done_r) |-> (phase_r == irpdv_pkg::PH_TAIL),
    "frame_done item but decoder not in tail")
  `IRPDV_ASSERT(a_abort_to_idle, clk, rst_n,
    (out_valid_r && out_abort_r) |-> (phase_r == irpdv_pkg::PH_IDLE),
    "frame_abort item but decoder not idle")
  `IRPDV_ASSERT(a_hold_only_idle, clk, rst_n,
    (hold_r != '0) |-> (phase_r == irpdv_pkg::PH_IDLE),
    "hold-down count running outside idle")

endmodule

[tb/ir_pulse_distance_volume_decoder_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ir_pulse_distance_volume_decoder_unit_tb
// Drives IR line samples through the decoder with random gaps and stalls on
// both channels, predicts every result item sample by sample from a local copy
// of the decode state, and compares each field of each result item.
// ---------------------------------------------------------------------------
module ir_pulse_distance_volume_decoder_unit_tb;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 120;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic       vol_up;
    logic       vol_down;
    logic       frame_done;
    logic       frame_abort;
    logic [7:0] address;
    logic [7:0] address_inv;
    logic [7:0] command;
    logic [7:0] command_inv;
  } decode_t;

  typedef enum int {
    FAULT_NONE,
    FAULT_LEAD_BURST,
    FAULT_LEAD_SPACE,
    FAULT_BIT_BURST,
    FAULT_BIT_SPACE
  } fault_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            drv_valid  = 1'b0;
  logic                            drv_level  = 1'b1;
  logic                            sink_ready = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic [irpdv_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [irpdv_pkg::CFG_DAT_W-1:0] cfg_data   = '0;

  irpdv_in_if  in_if ();
  irpdv_out_if out_if ();

  assign in_if.valid    = drv_valid;
  assign in_if.ir_level = drv_level;
  assign out_if.ready   = sink_ready;

  ir_pulse_distance_volume_decoder_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Register shadow, written only from the stimulus process
  logic [7:0]  dev_id         = irpdv_pkg::DEVICE_ID_RST;
  logic [7:0]  up_cmd         = irpdv_pkg::UP_CODE_RST;
  logic [7:0]  down_cmd       = irpdv_pkg::DOWN_CODE_RST;
  logic [15:0] lead_burst_lim = irpdv_pkg::LEAD_BURST_RST;
  logic [15:0] lead_space_lim = irpdv_pkg::LEAD_SPACE_RST;
  logic [15:0] bit_burst_lim  = irpdv_pkg::BIT_BURST_RST;
  logic [15:0] bit_space_lim  = irpdv_pkg::BIT_SPACE_RST;
  logic [15:0] one_lim        = irpdv_pkg::ONE_THRESH_RST;

  // Decode state of the predictor
  irpdv_pkg::phase_t ph;
  logic [15:0]       run_len;
  logic [5:0]        bit_cnt;
  logic [31:0]       shift_bits;
  logic [31:0]       frame_word;
  logic              up_on;
  logic              down_on;
  logic [14:0]       idle_run;

  logic    sample_q[$];
  decode_t decode_q[$];

  int   total_pushed   = 0;
  int   results_seen   = 0;
  int   fail_count     = 0;
  int   items_sent     = 0;
  int   gap_left       = 0;
  int   sink_hold      = 0;
  int   idle_cycles    = 0;
  logic calm           = 1'b0;
  logic drain_hold     = 1'b0;
  logic long_hold_done = 1'b0;

  function automatic void reset_decoder();
    ph         = irpdv_pkg::PH_IDLE;
    run_len    = '0;
    bit_cnt    = '0;
    shift_bits = '0;
    frame_word = '0;
    up_on      = 1'b0;
    down_on    = 1'b0;
    idle_run   = '0;
  endfunction

  function automatic void bump_run();
    if (run_len != irpdv_pkg::DUR_MAX) run_len = run_len + 16'd1;
  endfunction

  function automatic void clear_drives_on_hold();
    if (idle_run >= irpdv_pkg::HOLD_TICKS_L) begin
      up_on   = 1'b0;
      down_on = 1'b0;
    end
  endfunction

  function automatic decode_t decode_sample(input logic level);
    decode_t r;
    logic    done;
    logic    dropped;
    done    = 1'b0;
    dropped = 1'b0;
    case (ph)
      irpdv_pkg::PH_LEAD_LOW: begin
        if (!level) begin
          bump_run();
        end else if (run_len > lead_burst_lim) begin
          ph      = irpdv_pkg::PH_IDLE;
          dropped = 1'b1;
        end else begin
          ph      = irpdv_pkg::PH_LEAD_HIGH;
          run_len = irpdv_pkg::DUR_ONE;
        end
      end
      irpdv_pkg::PH_LEAD_HIGH: begin
        if (level) begin
          bump_run();
          if (run_len > lead_space_lim) begin
            ph      = irpdv_pkg::PH_IDLE;
            dropped = 1'b1;
          end
        end else begin
          ph         = irpdv_pkg::PH_BIT_LOW;
          run_len    = irpdv_pkg::DUR_ONE;
          bit_cnt    = '0;
          shift_bits = '0;
        end
      end
      irpdv_pkg::PH_BIT_LOW: begin
        if (!level) begin
          bump_run();
        end else if (run_len > bit_burst_lim) begin
          ph      = irpdv_pkg::PH_IDLE;
          dropped = 1'b1;
        end else begin
          ph      = irpdv_pkg::PH_BIT_HIGH;
          run_len = irpdv_pkg::DUR_ONE;
        end
      end
      irpdv_pkg::PH_BIT_HIGH: begin
        if (level) begin
          bump_run();
          if (run_len > bit_space_lim) begin
            ph      = irpdv_pkg::PH_IDLE;
            dropped = 1'b1;
          end
        end else begin
          // falling edge ends the space: decide the bit
          if (run_len > one_lim) shift_bits[bit_cnt[4:0]] = 1'b1;
          bit_cnt = bit_cnt + 6'd1;
          if (bit_cnt >= irpdv_pkg::FRAME_BITS_L || 32'(bit_cnt) >= irpdv_pkg::WORD_W) begin
            frame_word = shift_bits;
            if (frame_word[7:0] == dev_id) begin
              if (frame_word[23:16] == up_cmd) up_on = 1'b1;
              else if (frame_word[23:16] == down_cmd) down_on = 1'b1;
            end
            done = 1'b1;
            ph   = irpdv_pkg::PH_TAIL;
          end else begin
            ph      = irpdv_pkg::PH_BIT_LOW;
            run_len = irpdv_pkg::DUR_ONE;
          end
        end
      end
      irpdv_pkg::PH_TAIL: begin
        if (level) begin
          ph       = irpdv_pkg::PH_IDLE;
          idle_run = 15'd1;
          clear_drives_on_hold();
        end
      end
      default: begin
        ph = irpdv_pkg::PH_IDLE;
        if (level) begin
          if (idle_run < irpdv_pkg::HOLD_TICKS_L) begin
            idle_run = idle_run + 15'd1;
            clear_drives_on_hold();
          end
        end else begin
          idle_run = '0;
          ph       = irpdv_pkg::PH_LEAD_LOW;
          run_len  = irpdv_pkg::DUR_ONE;
        end
      end
    endcase
    if (ph != irpdv_pkg::PH_IDLE) idle_run = '0;
    r = '{up_on, down_on, done, dropped, frame_word[7:0], frame_word[15:8],
          frame_word[23:16], frame_word[31:24]};
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_if.ready) begin
      if (drain_hold) begin
        // hold off until every pending result item is back
        drv_valid <= 1'b0;
        if (!drv_valid && decode_q.size() == 0) drain_hold <= 1'b0;
      end else if (gap_left != 0) begin
        drv_valid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (sample_q.size() != 0) begin
        drv_valid  <= 1'b1;
        drv_level  <= sample_q.pop_front();
        gap_left   <= pick_gap();
        items_sent <= items_sent + 1;
        if (items_sent % 64 == 0) calm <= ($urandom_range(0, 3) == 0);
        if (items_sent == 300 || $urandom_range(0, 399) == 0) drain_hold <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Result sink
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_ready <= 1'b0;
      sink_hold  <= sink_hold - 1;
    end else if (!long_hold_done && results_seen >= 400) begin
      // long stall so the output fills and the input backs up
      sink_ready     <= 1'b0;
      sink_hold      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      sink_ready <= 1'b0;
      sink_hold  <= pick_gap();
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Predict on accepted samples, compare on accepted results
  always @(posedge clk) begin
    decode_t got;
    decode_t want;
    if (!rst_n) begin
      reset_decoder();
      decode_q.delete();
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.vol_up, out_if.vol_down, out_if.frame_done, out_if.frame_abort,
               out_if.rx_address, out_if.rx_address_inv, out_if.rx_command,
               out_if.rx_command_inv};
        results_seen++;
        if (decode_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing pending, expected none, got %h", $time, got);
        end else begin
          want = decode_q.pop_front();
          check_field("vol_up", 8'(want.vol_up), 8'(got.vol_up));
          check_field("vol_down", 8'(want.vol_down), 8'(got.vol_down));
          check_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
          check_field("frame_abort", 8'(want.frame_abort), 8'(got.frame_abort));
          check_field("rx_address", want.address, got.address);
          check_field("rx_address_inv", want.address_inv, got.address_inv);
          check_field("rx_command", want.command, got.command);
          check_field("rx_command_inv", want.command_inv, got.command_inv);
        end
      end
      if (in_if.valid && in_if.ready) decode_q.push_back(decode_sample(in_if.ir_level));
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic queue_run(input logic level, input int n);
    repeat (n) sample_q.push_back(level);
    total_pushed += n;
  endtask

  task automatic settle();
    while (results_seen < total_pushed) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input irpdv_pkg::cfg_reg_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      irpdv_pkg::REG_DEVICE_ID:  dev_id         = val[7:0];
      irpdv_pkg::REG_UP_CODE:    up_cmd         = val[7:0];
      irpdv_pkg::REG_DOWN_CODE:  down_cmd       = val[7:0];
      irpdv_pkg::REG_LEAD_BURST: lead_burst_lim = val;
      irpdv_pkg::REG_LEAD_SPACE: lead_space_lim = val;
      irpdv_pkg::REG_BIT_BURST:  bit_burst_lim  = val;
      irpdv_pkg::REG_BIT_SPACE:  bit_space_lim  = val;
      default:                   one_lim        = val;
    endcase
  endtask

  task automatic set_regs(input logic [7:0] dev, input logic [7:0] up,
                          input logic [7:0] down, input logic [15:0] lb,
                          input logic [15:0] ls, input logic [15:0] bb,
                          input logic [15:0] bs, input logic [15:0] one);
    settle();
    write_reg(irpdv_pkg::REG_DEVICE_ID, 16'(dev));
    write_reg(irpdv_pkg::REG_UP_CODE, 16'(up));
    write_reg(irpdv_pkg::REG_DOWN_CODE, 16'(down));
    write_reg(irpdv_pkg::REG_LEAD_BURST, lb);
    write_reg(irpdv_pkg::REG_LEAD_SPACE, ls);
    write_reg(irpdv_pkg::REG_BIT_BURST, bb);
    write_reg(irpdv_pkg::REG_BIT_SPACE, bs);
    write_reg(irpdv_pkg::REG_ONE_THRESH, one);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int clip(input int lim, input int top);
    if (lim < 1) return 1;
    return (lim > top) ? top : lim;
  endfunction

  function automatic int low_len(input logic [15:0] lim);
    return $urandom_range(1, clip(int'(lim), 6));
  endfunction

  // high run that trips its limit on its last tick, then a little idle
  function automatic int over_high(input logic [15:0] lim);
    int m;
    m = int'(lim) + 1;
    if (m < 2) m = 2;
    return m + $urandom_range(0, 2);
  endfunction

  function automatic int space_len(input logic b);
    int cap;
    cap = clip(int'(bit_space_lim), 8);
    if (b) return (int'(one_lim) < cap) ? $urandom_range(int'(one_lim) + 1, cap) : cap;
    return $urandom_range(1, clip(int'(one_lim), cap));
  endfunction

  // Leader, FRAME_BITS pulse-distance bits LSB first, stop burst, idle.
  // A fault breaks one segment past its limit and drops the rest.
  task automatic queue_frame(input logic [31:0] word, input fault_t fault);
    int at;
    at = $urandom_range(0, irpdv_pkg::FRAME_BITS - 1);
    if (fault == FAULT_LEAD_BURST) begin
      queue_run(1'b0, int'(lead_burst_lim) + 1 + $urandom_range(0, 2));
      queue_run(1'b1, $urandom_range(1, 4));
      return;
    end
    queue_run(1'b0, low_len(lead_burst_lim));
    if (fault == FAULT_LEAD_SPACE) begin
      queue_run(1'b1, over_high(lead_space_lim));
      return;
    end
    queue_run(1'b1, $urandom_range(1, clip(int'(lead_space_lim), 6)));
    for (int i = 0; i < irpdv_pkg::FRAME_BITS; i++) begin
      if (fault == FAULT_BIT_BURST && i == at) begin
        queue_run(1'b0, int'(bit_burst_lim) + 1 + $urandom_range(0, 2));
        queue_run(1'b1, $urandom_range(1, 4));
        return;
      end
      queue_run(1'b0, low_len(bit_burst_lim));
      if (fault == FAULT_BIT_SPACE && i == at) begin
        queue_run(1'b1, over_high(bit_space_lim));
        return;
      end
      queue_run(1'b1, space_len(word[i]));
    end
    queue_run(1'b0, $urandom_range(1, 3));
    queue_run(1'b1, $urandom_range(1, 6));
  endtask

  task automatic random_phase();
    logic [7:0]  dev;
    logic [7:0]  up;
    logic [7:0]  down;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [15:0] bs;
    logic [31:0] word;
    int          start;
    int          r;
    dev  = 8'($urandom);
    up   = 8'($urandom);
    down = ($urandom_range(0, 5) == 0) ? up : 8'($urandom);
    bs   = 16'($urandom_range(1, 6));
    set_regs(dev, up, down, 16'($urandom_range(1, 8)), 16'($urandom_range(0, 6)),
             16'($urandom_range(1, 4)), bs, 16'($urandom_range(0, int'(bs))));
    start = total_pushed;
    while (total_pushed - start < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        addr = ($urandom_range(0, 3) != 0) ? dev : 8'($urandom);
        case ($urandom_range(0, 2))
          0:       cmd = up;
          1:       cmd = down;
          default: cmd = 8'($urandom);
        endcase
        word = {($urandom_range(0, 1) != 0) ? ~cmd : 8'($urandom), cmd,
                ($urandom_range(0, 1) != 0) ? ~addr : 8'($urandom), addr};
        queue_frame(word, ($urandom_range(0, 9) == 0) ? fault_t'($urandom_range(1, 4))
                                                     : FAULT_NONE);
      end else if (r < 86) begin
        repeat ($urandom_range(1, 20)) queue_run(1'($urandom_range(0, 1)), 1);
        // long enough high to trip any space limit of this phase
        queue_run(1'b1, 10);
      end else begin
        queue_run(1'b1, $urandom_range(1, 30));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Idle line straight out of reset
    queue_run(1'b1, 6);

    // Tight limits, extreme address and codes
    set_regs(8'hFF, 8'h00, 8'hFF, 16'd4, 16'd3, 16'd2, 16'd4, 16'd2);
    queue_frame({8'hFF, 8'h00, 8'h00, 8'hFF}, FAULT_NONE);
    queue_frame({8'h00, 8'hFF, 8'h00, 8'hFF}, FAULT_NONE);
    queue_frame($urandom, FAULT_LEAD_BURST);
    queue_frame($urandom, FAULT_LEAD_SPACE);
    queue_frame($urandom, FAULT_BIT_BURST);
    queue_frame($urandom, FAULT_BIT_SPACE);

    // Equal codes and minimum limits: every space is a one
    set_regs(8'hFF, 8'hFF, 8'hFF, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0);
    queue_frame('1, FAULT_NONE);
    queue_frame($urandom, FAULT_LEAD_SPACE);
    queue_frame($urandom, FAULT_BIT_SPACE);

    // Zero leader burst limit: any leader drops
    set_regs(8'h00, 8'h01, 8'h00, 16'd0, irpdv_pkg::DUR_MAX, irpdv_pkg::DUR_MAX,
             irpdv_pkg::DUR_MAX, irpdv_pkg::DUR_MAX);
    queue_run(1'b0, 1);
    queue_run(1'b1, 2);

    repeat (2) random_phase();

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
